### rtl/core/mbg_pkg.sv
package mbg_pkg;

    localparam int BPM_W = 10;
    localparam int BEATS_W = 3;
    localparam int MS_W = 16;
    localparam int FLASH_W = 8;
    localparam int DEB_W = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_PULSE = 2'd1;
    localparam logic [1:0] OP_DIR = 2'd2;
    localparam logic [1:0] OP_BUTTON = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BPM = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BPM = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BEATS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BEATS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE_MS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_MS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MENU_MS = 3'd7;

    localparam logic [MS_W:0] MS_PER_MINUTE = 17'd60000;
    localparam logic [MS_W-1:0] ZERO_BPM_PERIOD = 16'hFFFF;
    localparam int DIV_STEPS = MS_W;

    typedef struct packed {
        logic div_start;
        logic apply;
        logic load;
    } mbg_cmd_t;

    typedef struct packed {
        logic div_done;
    } mbg_status_t;

    typedef struct packed {
        logic led_on;
        logic sound_on;
        logic accent;
        logic [BPM_W-1:0] tempo_bpm;
        logic [BEATS_W-1:0] bar_beats;
        logic menu_page;
        logic muted;
    } mbg_result_t;

endpackage

### rtl/core/mbg_ctrl.sv
module mbg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 out_busy,
    input  mbg_pkg::mbg_status_t status,
    output mbg_pkg::mbg_cmd_t    cmd
);
    import mbg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0] state_reg, state_next;
    logic accept;

    assign s_tready = (state_reg == ST_IDLE) && !out_busy;
    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                cmd.apply = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply |=> (state_reg == ST_IDLE))
        else $error("apply not followed by idle");
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_DIV))
        else $error("accept did not start divide");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("ready while busy");

endmodule

### rtl/core/mbg_datapath.sv
module mbg_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mbg_pkg::mbg_cmd_t             cmd,
    output mbg_pkg::mbg_status_t          status,
    input  logic [1:0]                    in_opcode,
    input  logic                          in_pulse,
    input  logic                          in_dir,
    input  logic                          cfg_valid,
    input  logic [mbg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data,
    output mbg_pkg::mbg_result_t          result
);
    import mbg_pkg::*;

    // configuration
    logic [BPM_W-1:0] min_bpm_reg, max_bpm_reg;
    logic [BEATS_W-1:0] min_beats_reg, max_beats_reg;
    logic [MS_W-1:0] mute_ms_reg, menu_ms_reg;
    logic [FLASH_W-1:0] flash_ms_reg;
    logic [DEB_W-1:0] deb_ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_bpm_reg <= 10'd10;
            max_bpm_reg <= 10'd999;
            min_beats_reg <= 3'd2;
            max_beats_reg <= 3'd4;
            mute_ms_reg <= 16'd1000;
            flash_ms_reg <= 8'd30;
            deb_ms_reg <= 3'd4;
            menu_ms_reg <= 16'd5000;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_BPM: min_bpm_reg <= cfg_data[BPM_W-1:0];
                CFG_MAX_BPM: max_bpm_reg <= cfg_data[BPM_W-1:0];
                CFG_MIN_BEATS: min_beats_reg <= cfg_data[BEATS_W-1:0];
                CFG_MAX_BEATS: max_beats_reg <= cfg_data[BEATS_W-1:0];
                CFG_MUTE_MS: mute_ms_reg <= cfg_data;
                CFG_FLASH_MS: flash_ms_reg <= cfg_data[FLASH_W-1:0];
                CFG_DEBOUNCE_MS: deb_ms_reg <= cfg_data[DEB_W-1:0];
                CFG_MENU_MS: menu_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // latched item
    logic [1:0] op_reg;
    logic pulse_reg, dir_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= in_opcode;
            pulse_reg <= in_pulse;
            dir_reg <= in_dir;
        end
    end

    // state
    logic [BPM_W-1:0] bpm_reg, bpm_next;
    logic [BEATS_W-1:0] beats_reg, beats_next;
    logic page_reg, page_next;
    logic [1:0] cw_reg, cw_next, ccw_reg, ccw_next;
    logic leq_reg, leq_next, lock_reg, lock_next, mute_reg, mute_next;
    logic [DEB_W-1:0] lockc_reg, lockc_next;
    logic [MS_W-1:0] mutec_reg, mutec_next, lastp_reg, lastp_next;
    logic [MS_W-1:0] msb_reg, msb_next, menuc_reg, menuc_next;
    logic [BEATS_W-1:0] bib_reg, bib_next;
    logic [FLASH_W-1:0] flc_reg, flc_next;
    logic led_reg, led_next, snd_reg, snd_next, acc_reg, acc_next;

    // restoring divider: 60000 / bpm, one quotient bit per cycle
    logic [MS_W-1:0] quo_reg;
    logic [BPM_W:0] rem_reg;
    logic [3:0] dcnt_reg;
    logic dbusy_reg;
    logic [BPM_W:0] rem_sh;
    logic rem_ge;

    assign rem_sh = {rem_reg[BPM_W-1:0], MS_PER_MINUTE[dcnt_reg]};
    assign rem_ge = rem_sh >= {1'b0, bpm_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dbusy_reg <= 1'b0;
            dcnt_reg <= '0;
        end else if (cmd.div_start) begin
            dbusy_reg <= 1'b1;
            dcnt_reg <= 4'(DIV_STEPS - 1);
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (dbusy_reg) begin
            rem_reg <= rem_ge ? rem_sh - {1'b0, bpm_reg} : rem_sh;
            quo_reg <= {quo_reg[MS_W-2:0], rem_ge};
            if (dcnt_reg == 4'd0) begin
                dbusy_reg <= 1'b0;
            end else begin
                dcnt_reg <= dcnt_reg - 4'd1;
            end
        end
    end
    // 60000 < 2^16 so bit 16 of the dividend is zero and 16 steps suffice
    assign status.div_done = dbusy_reg && (dcnt_reg == 4'd0);

    logic [MS_W-1:0] period;
    assign period = (bpm_reg == '0) ? ZERO_BPM_PERIOD : quo_reg;

    logic equal, is_pulse, cw, up;
    assign equal = (pulse_reg == dir_reg);

    always_comb begin
        bpm_next = bpm_reg; beats_next = beats_reg; page_next = page_reg;
        cw_next = cw_reg; ccw_next = ccw_reg; leq_next = leq_reg;
        lock_next = lock_reg; lockc_next = lockc_reg;
        mute_next = mute_reg; mutec_next = mutec_reg;
        lastp_next = lastp_reg; msb_next = msb_reg; bib_next = bib_reg;
        flc_next = flc_reg; led_next = led_reg; snd_next = snd_reg;
        acc_next = acc_reg; menuc_next = menuc_reg;
        is_pulse = (op_reg == OP_PULSE);
        cw = is_pulse ? equal : !equal;
        up = 1'b0;
        case (op_reg)
            OP_TICK: begin
                if (mute_next) begin
                    mutec_next = mutec_next + 16'd1;
                    led_next = 1'b0; msb_next = '0; snd_next = 1'b0; bib_next = 3'd1;
                    if (mutec_next >= mute_ms_reg) begin
                        mute_next = 1'b0; mutec_next = '0;
                    end
                end
                if (period != lastp_next && !mute_next) begin
                    led_next = 1'b0; msb_next = '0; lastp_next = period;
                    snd_next = 1'b0; bib_next = 3'd1;
                end
                msb_next = msb_next + 16'd1;
                if (msb_next == period && !mute_next) begin
                    led_next = 1'b1; snd_next = 1'b1; msb_next = '0;
                    acc_next = (bib_next == beats_reg);
                    bib_next = (bib_next + 3'd1 > beats_reg || bib_next == 3'd7)
                               ? 3'd1 : bib_next + 3'd1;
                end
                if (led_next) begin
                    flc_next = flc_next + 8'd1;
                    if (flc_next >= flash_ms_reg) begin
                        flc_next = '0; led_next = 1'b0; snd_next = 1'b0;
                    end
                end
                if (lock_next) begin
                    snd_next = 1'b0;
                    lockc_next = lockc_next + 3'd1;
                    if (lockc_next >= deb_ms_reg) begin
                        lockc_next = '0; lock_next = 1'b0; leq_next = equal;
                    end
                end
                if (page_next) begin
                    menuc_next = menuc_next + 16'd1;
                    if (menuc_next >= menu_ms_reg) begin
                        page_next = 1'b0; menuc_next = '0;
                    end
                end
            end
            OP_PULSE, OP_DIR: begin
                mute_next = 1'b1; mutec_next = '0; menuc_next = '0;
                if (!lock_reg) begin
                    if (cw) begin
                        ccw_next = '0;
                        if (leq_reg != equal) begin
                            cw_next = cw_reg + 2'd1;
                            if (cw_next == 2'd2) begin
                                up = 1'b1; cw_next = '0;
                                if (page_reg) begin
                                    beats_next = (beats_reg == 3'd7 || beats_reg + 3'd1 > max_beats_reg)
                                                 ? max_beats_reg : beats_reg + 3'd1;
                                end else begin
                                    bpm_next = ({1'b0, bpm_reg} + 11'd1 > {1'b0, max_bpm_reg})
                                               ? max_bpm_reg : bpm_reg + 10'd1;
                                end
                            end
                        end
                    end else begin
                        cw_next = '0;
                        if (leq_reg != equal) begin
                            ccw_next = ccw_reg + 2'd1;
                            if (ccw_next == 2'd2) begin
                                ccw_next = '0;
                                if (page_reg) begin
                                    if (beats_reg > min_beats_reg) beats_next = beats_reg - 3'd1;
                                end else begin
                                    if (bpm_reg > min_bpm_reg) bpm_next = bpm_reg - 10'd1;
                                end
                            end
                        end
                    end
                    leq_next = equal;
                    lock_next = 1'b1;
                end
            end
            default: begin
                mute_next = 1'b1; mutec_next = '0; menuc_next = '0;
                page_next = !page_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpm_reg <= 10'd50; beats_reg <= 3'd4; page_reg <= 1'b0;
            cw_reg <= '0; ccw_reg <= '0; leq_reg <= 1'b0;
            lock_reg <= 1'b0; lockc_reg <= '0; mute_reg <= 1'b0; mutec_reg <= '0;
            lastp_reg <= 16'd50; msb_reg <= '0; bib_reg <= 3'd1; flc_reg <= '0;
            led_reg <= 1'b0; snd_reg <= 1'b0; acc_reg <= 1'b0; menuc_reg <= '0;
        end else if (cmd.apply) begin
            bpm_reg <= bpm_next; beats_reg <= beats_next; page_reg <= page_next;
            cw_reg <= cw_next; ccw_reg <= ccw_next; leq_reg <= leq_next;
            lock_reg <= lock_next; lockc_reg <= lockc_next;
            mute_reg <= mute_next; mutec_reg <= mutec_next;
            lastp_reg <= lastp_next; msb_reg <= msb_next; bib_reg <= bib_next;
            flc_reg <= flc_next; led_reg <= led_next; snd_reg <= snd_next;
            acc_reg <= acc_next; menuc_reg <= menuc_next;
        end
    end

    always_comb begin
        result.led_on = led_next;
        result.sound_on = snd_next && !mute_next;
        result.accent = acc_next;
        result.tempo_bpm = bpm_next;
        result.bar_beats = beats_next;
        result.menu_page = page_next;
        result.muted = mute_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |=> dbusy_reg)
        else $error("divider did not start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.apply && up && !page_reg) |=> (bpm_reg <= max_bpm_reg))
        else $error("tempo increment passed max");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply |-> !dbusy_reg)
        else $error("apply during divide");

endmodule

### rtl/core/metronome_beat_generator.sv
// Metronome core. Every input transfer is a 1 ms tick, an encoder pulse or
// direction edge (with both line levels) or a button press, and each one
// produces exactly one result transfer with the LED, sound, accent, tempo,
// bar length, menu page and mute flags after the update. The accepting edge
// latches the item and starts the bit-serial divider computing 60000 / tempo;
// once the divider is done, the apply state commits the state and registers
// the result. The next item is accepted only after that, once the result
// register is free or being drained, so items never overlap in the core.
// Configuration writes are taken whenever cfg_valid is high and must only be
// issued while the core is idle.
module metronome_beat_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // opcode[1:0], pulse_level[2], dir_level[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    // led_on, sound_on, accent, tempo_bpm[9:0], bar_beats[2:0], menu_page, muted
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import mbg_pkg::*;

    mbg_cmd_t cmd;
    mbg_status_t status;
    mbg_result_t result;
    logic out_busy;
    logic [23:0] out_reg;
    logic outv_reg;

    // result register holds until transferred
    assign out_busy = outv_reg && !m_tready;
    assign cfg_ready = 1'b1;

    mbg_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .out_busy(out_busy), .status(status), .cmd(cmd)
    );

    mbg_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .status(status),
        .in_opcode(s_tdata[1:0]), .in_pulse(s_tdata[2]), .in_dir(s_tdata[3]),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result(result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outv_reg <= 1'b0;
        end else if (cmd.apply) begin
            outv_reg <= 1'b1;
        end else if (m_tready) begin
            outv_reg <= 1'b0;
        end
    end

    // apply only comes after an accept, which needed out_busy low
    always_ff @(posedge aclk) begin
        if (cmd.apply) begin
            out_reg <= {6'd0, result.muted, result.menu_page, result.bar_beats,
                        result.tempo_bpm, result.accent, result.sound_on, result.led_on};
        end
    end

    assign m_tvalid = outv_reg;
    assign m_tdata = out_reg;

endmodule

### tb/metronome_beat_generator_tb.sv
`timescale 1ns / 1ps

module metronome_beat_generator_tb;
    import mbg_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    metronome_beat_generator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // predictor copy of the configuration
    logic [9:0]  p_min_bpm, p_max_bpm;
    logic [2:0]  p_min_beats, p_max_beats;
    logic [15:0] p_mute_ms, p_menu_ms;
    logic [7:0]  p_flash_ms;
    logic [2:0]  p_deb_ms;

    // predictor copy of the state
    logic [9:0]  bpm;
    logic [2:0]  beats, beat_in_bar, lock_cnt;
    logic        page, lines_eq, lock_on, mute_on, led, snd, acc;
    logic [1:0]  cw_cnt, ccw_cnt;
    logic [15:0] mute_cnt, last_per, ms_cnt, menu_cnt;
    logic [7:0]  flash_cnt;

    mbg_result_t result_q[$];
    int          errors;
    longint      cycles;
    int          results_seen;

    function automatic logic [23:0] pack_result(mbg_result_t r);
        // led_on lowest, muted highest, same as the port packing
        return {6'd0, r.muted, r.menu_page, r.bar_beats, r.tempo_bpm,
                r.accent, r.sound_on, r.led_on};
    endfunction

    task automatic metro_reset();
        p_min_bpm = 10'd10; p_max_bpm = 10'd999; p_min_beats = 3'd2; p_max_beats = 3'd4;
        p_mute_ms = 16'd1000; p_flash_ms = 8'd30; p_deb_ms = 3'd4; p_menu_ms = 16'd5000;
        bpm = 10'd50; beats = 3'd4; page = 1'b0; cw_cnt = 2'd0; ccw_cnt = 2'd0;
        lines_eq = 1'b0; lock_on = 1'b0; lock_cnt = 3'd0; mute_on = 1'b0;
        mute_cnt = 16'd0;
        last_per = 16'd50; ms_cnt = 16'd0; beat_in_bar = 3'd1; flash_cnt = 8'd0;
        led = 1'b0; snd = 1'b0; acc = 1'b0; menu_cnt = 16'd0;
    endtask

    task automatic metro_config(logic [2:0] idx, logic [15:0] val);
        case (idx)
            CFG_MIN_BPM:     p_min_bpm = val[9:0];
            CFG_MAX_BPM:     p_max_bpm = val[9:0];
            CFG_MIN_BEATS:   p_min_beats = val[2:0];
            CFG_MAX_BEATS:   p_max_beats = val[2:0];
            CFG_MUTE_MS:     p_mute_ms = val;
            CFG_FLASH_MS:    p_flash_ms = val[7:0];
            CFG_DEBOUNCE_MS: p_deb_ms = val[2:0];
            CFG_MENU_MS:     p_menu_ms = val;
            default:         ;
        endcase
    endtask

    task automatic step_setting(logic up);
        if (page == 1'b0) begin
            if (up) bpm = ({1'b0, bpm} + 11'd1 > {1'b0, p_max_bpm}) ? p_max_bpm
                                                                    : bpm + 10'd1;
            else if (bpm > p_min_bpm) bpm = bpm - 10'd1;
        end else begin
            if (up) beats = ({1'b0, beats} + 4'd1 > {1'b0, p_max_beats}) ? p_max_beats
                                                                        : beats + 3'd1;
            else if (beats > p_min_beats) beats = beats - 3'd1;
        end
    endtask

    task automatic metro_step(logic [1:0] op, logic pl, logic dl);
        logic        eq;
        logic        cw;
        logic [15:0] per;
        logic [3:0]  nb;
        mbg_result_t r;
        eq = (pl == dl);
        if (op == OP_TICK) begin
            per = (bpm == 10'd0) ? ZERO_BPM_PERIOD : 16'(60000 / bpm);
            if (mute_on) begin
                mute_cnt = mute_cnt + 16'd1;
                led = 1'b0; ms_cnt = 16'd0; snd = 1'b0; beat_in_bar = 3'd1;
                if (mute_cnt >= p_mute_ms) begin
                    mute_on = 1'b0; mute_cnt = 16'd0;
                end
            end
            if (per != last_per && !mute_on) begin
                led = 1'b0; ms_cnt = 16'd0; last_per = per; snd = 1'b0;
                beat_in_bar = 3'd1;
            end
            ms_cnt = ms_cnt + 16'd1;
            if (ms_cnt == per && !mute_on) begin
                led = 1'b1; snd = 1'b1; ms_cnt = 16'd0;
                acc = (beat_in_bar == beats);
                nb = {1'b0, beat_in_bar} + 4'd1;
                if (nb > {1'b0, beats}) nb = 4'd1;
                beat_in_bar = nb[2:0];
            end
            if (led) begin
                flash_cnt = flash_cnt + 8'd1;
                if (flash_cnt >= p_flash_ms) begin
                    flash_cnt = 8'd0; led = 1'b0; snd = 1'b0;
                end
            end
            if (lock_on) begin
                snd = 1'b0;
                lock_cnt = lock_cnt + 3'd1;
                if (lock_cnt >= p_deb_ms) begin
                    lock_cnt = 3'd0; lock_on = 1'b0; lines_eq = eq;
                end
            end
            if (page) begin
                menu_cnt = menu_cnt + 16'd1;
                if (menu_cnt >= p_menu_ms) begin
                    page = 1'b0; menu_cnt = 16'd0;
                end
            end
        end else begin
            mute_on = 1'b1; mute_cnt = 16'd0; menu_cnt = 16'd0;
            if (op == OP_BUTTON) begin
                page = ~page;
            end else if (!lock_on) begin
                cw = (op == OP_PULSE) ? eq : !eq;
                if (cw) begin
                    ccw_cnt = 2'd0;
                    if (lines_eq != eq) begin
                        cw_cnt = cw_cnt + 2'd1;
                        if (cw_cnt == 2'd2) begin
                            step_setting(1'b1); cw_cnt = 2'd0;
                        end
                    end
                end else begin
                    cw_cnt = 2'd0;
                    if (lines_eq != eq) begin
                        ccw_cnt = ccw_cnt + 2'd1;
                        if (ccw_cnt == 2'd2) begin
                            step_setting(1'b0); ccw_cnt = 2'd0;
                        end
                    end
                end
                lines_eq = eq;
                lock_on = 1'b1;
            end
        end
        r.led_on = led; r.sound_on = snd && !mute_on; r.accent = acc;
        r.tempo_bpm = bpm; r.bar_beats = beats; r.menu_page = page; r.muted = mute_on;
        result_q.push_back(r);
    endtask

    // driver side; valid stays high into a back-to-back item
    task automatic send_item(logic [1:0] op, logic pl, logic dl);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, dl, pl, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        metro_step(op, pl, dl);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        metro_config(idx, val);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // random encoder turns: detents in a random direction each, with noise
    task automatic rand_burst(int n);
        logic pl, dl;
        int   k, dir;
        pl = 1'($urandom_range(0, 1)); dl = 1'($urandom_range(0, 1));
        k = 0;
        while (k < n) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // one detent: alternate edges, each followed by random ticks that may clear the lockout
                    dir = $urandom_range(0, 1);
                    repeat (2) begin
                        if (dir != 0) begin pl = ~pl; send_item(OP_PULSE, pl, dl); end
                        else          begin dl = ~dl; send_item(OP_DIR, pl, dl); end
                        repeat ($urandom_range(0, 9)) begin
                            send_item(OP_TICK, pl, dl); k++;
                        end
                        k++;
                    end
                end
                3: begin
                    send_item(OP_BUTTON, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    k++;
                end
                4: begin
                    send_item(2'($urandom_range(1, 2)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                    k++;
                end
                default: begin
                    repeat ($urandom_range(1, 40)) begin
                        send_item(OP_TICK, pl, dl); k++;
                    end
                end
            endcase
        end
    endtask

    // directed table; exp_chk marks rows with a typed-in result
    typedef struct {
        logic [1:0] op;
        logic       pl;
        logic       dl;
        logic       exp_chk;
        logic [23:0] exp;
    } dir_row_t;

    dir_row_t dir_tab[] = '{
        '{OP_TICK,   0, 0, 1, {6'd0, 1'b0, 1'b0, 3'd4, 10'd50, 3'b000}},
        '{OP_TICK,   1, 1, 0, 24'd0},
        '{OP_BUTTON, 0, 0, 1, {6'd0, 1'b1, 1'b1, 3'd4, 10'd50, 3'b000}},
        '{OP_BUTTON, 1, 1, 1, {6'd0, 1'b1, 1'b0, 3'd4, 10'd50, 3'b000}},
        '{OP_PULSE,  1, 0, 0, 24'd0},
        '{OP_TICK,   1, 0, 0, 24'd0},
        '{OP_TICK,   1, 0, 0, 24'd0},
        '{OP_PULSE,  0, 0, 0, 24'd0},
        '{OP_PULSE,  1, 0, 0, 24'd0},
        '{OP_TICK,   1, 0, 0, 24'd0},
        '{OP_TICK,   1, 0, 0, 24'd0},
        '{OP_TICK,   1, 0, 0, 24'd0},
        '{OP_DIR,    1, 1, 0, 24'd0},
        '{OP_TICK,   1, 1, 0, 24'd0},
        '{OP_TICK,   1, 1, 0, 24'd0},
        '{OP_DIR,    1, 0, 0, 24'd0},
        '{OP_TICK,   1, 0, 0, 24'd0},
        '{OP_DIR,    0, 1, 0, 24'd0},
        '{OP_TICK,   0, 1, 0, 24'd0},
        '{OP_TICK,   0, 1, 0, 24'd0}
    };

    logic [23:0] dir_exp_q[$];
    logic        dir_chk_q[$];

    // result checker with random back-pressure
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, m_tdata);
                errors++;
            end else begin
                mbg_result_t e;
                e = result_q.pop_front();
                if (m_tdata !== pack_result(e)) begin
                    $display("%0t: result mismatch expected %h actual %h",
                             $realtime, pack_result(e), m_tdata);
                    errors++;
                end
                if (dir_chk_q.size() != 0) begin
                    if (dir_chk_q.pop_front() && m_tdata !== dir_exp_q[0]) begin
                        $display("%0t: directed mismatch expected %h actual %h",
                                 $realtime, dir_exp_q[0], m_tdata);
                        errors++;
                    end
                    void'(dir_exp_q.pop_front());
                end
            end
            results_seen++;
        end
    end

    int stall_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (m_tvalid && m_tready || !m_tvalid && stall_left == 0) begin
            stall_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            m_tready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= (stall_left == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        errors = 0; cycles = 0; results_seen = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0; s_tdata = 8'd0;
        cfg_valid = 1'b0; cfg_index = 3'd0; cfg_data = 16'd0;
        metro_reset();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part at reset configuration
        foreach (dir_tab[i]) begin
            dir_chk_q.push_back(dir_tab[i].exp_chk);
            dir_exp_q.push_back(dir_tab[i].exp);
            send_item(dir_tab[i].op, dir_tab[i].pl, dir_tab[i].dl);
        end
        drain();

        // short times so beats and flashes happen often
        write_reg(CFG_MUTE_MS, 16'd3);
        write_reg(CFG_FLASH_MS, 16'd2);
        write_reg(CFG_DEBOUNCE_MS, 16'd1);
        write_reg(CFG_MENU_MS, 16'd40);
        write_reg(CFG_MIN_BPM, 16'd1000);
        write_reg(CFG_MAX_BPM, 16'd1023);
        write_reg(CFG_MIN_BEATS, 16'd1);
        write_reg(CFG_MAX_BEATS, 16'd7);
        rand_burst(300);
        drain();

        // extremes, including zero limits and zero times
        write_reg(CFG_MIN_BPM, 16'd0);
        write_reg(CFG_MAX_BPM, 16'd1);
        write_reg(CFG_MIN_BEATS, 16'd0);
        write_reg(CFG_MAX_BEATS, 16'd0);
        write_reg(CFG_MUTE_MS, 16'd0);
        write_reg(CFG_FLASH_MS, 16'd255);
        write_reg(CFG_DEBOUNCE_MS, 16'd7);
        write_reg(CFG_MENU_MS, 16'd0);
        rand_burst(300);
        drain();

        write_reg(CFG_MIN_BPM, 16'd1020);
        write_reg(CFG_MAX_BPM, 16'd1023);
        write_reg(CFG_MUTE_MS, 16'hFFFF);
        write_reg(CFG_FLASH_MS, 16'd0);
        write_reg(CFG_DEBOUNCE_MS, 16'd0);
        write_reg(CFG_MENU_MS, 16'hFFFF);
        write_reg(CFG_MIN_BEATS, 16'd7);
        write_reg(CFG_MAX_BEATS, 16'd7);
        rand_burst(250);
        drain();

        // random settings with short timings
        repeat (4) begin
            write_reg(CFG_MIN_BPM, 16'($urandom_range(0, 1023)));
            write_reg(CFG_MAX_BPM, 16'($urandom_range(0, 1023)));
            write_reg(CFG_MIN_BEATS, 16'($urandom_range(0, 7)));
            write_reg(CFG_MAX_BEATS, 16'($urandom_range(0, 7)));
            write_reg(CFG_MUTE_MS, 16'($urandom_range(0, 6)));
            write_reg(CFG_FLASH_MS, 16'($urandom_range(0, 8)));
            write_reg(CFG_DEBOUNCE_MS, 16'($urandom_range(0, 7)));
            write_reg(CFG_MENU_MS, 16'($urandom_range(0, 60)));
            rand_burst(200);
            drain();
        end

        if (errors == 0 && result_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
